@@ src/hw3v_pkg.sv @@
// package for the separable 3d hann window voxel unit
// widths, register indexes and the elaboration-time cosine quarter-wave builder
// no dependencies
`default_nettype none

package hw3v_pkg;

  localparam int SAMPLE_W   = 18;
  localparam int COORD_W    = 13;
  localparam int STEP_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int QW_W       = 15;
  localparam int WEIGHT_W   = 16;
  localparam int PIPE_DEPTH = 6;
  localparam int AMP        = 32767;

  localparam logic [63:0] Q60_ONE        = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_QUARTER_Q60 = 64'h0C90_FDAA_2216_8C23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_ROW   = 2'd0,
    CFG_STEP_COL   = 2'd1,
    CFG_STEP_LAYER = 2'd2,
    CFG_WINDOW_ON  = 2'd3
  } cfg_idx_e;

  // (a*b) >> 60
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, ll, mid, high;
    ah   = a >> 32;
    al   = a & 64'hFFFF_FFFF;
    bh   = b >> 32;
    bl   = b & 64'hFFFF_FFFF;
    ll   = al * bl;
    mid  = ah * bl + al * bh + (ll >> 32);
    high = ah * bh + (mid >> 32);
    return (high << 4) + ((mid & 64'hFFFF_FFFF) >> 28);
  endfunction

  // quotient by restoring long division, den below 2^63
  function automatic logic [63:0] div_q60(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo, rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] angle_q60(input int tb, input logic [63:0] t);
    int          sh;
    logic [63:0] lowmask;
    sh      = tb - 3;
    lowmask = (64'd1 << sh) - 64'd1;
    return (PI_QUARTER_Q60 >> sh) * t + (((PI_QUARTER_Q60 & lowmask) * t) >> sh);
  endfunction

  function automatic logic [63:0] trig_q60(input logic [63:0] x, input logic want_sin);
    logic [63:0] x2, term, sum, d;
    x2   = mul_q60(x, x);
    term = want_sin ? x : Q60_ONE;
    sum  = term;
    for (int n = 1; n <= 24; n++) begin
      d    = want_sin ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = div_q60(mul_q60(term, x2), d);
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [QW_W-1:0] scale_round(input logic [63:0] v);
    logic [63:0] a, b, c, r;
    a = 64'(AMP) * (v >> 30);
    b = 64'(AMP) * (v & 64'h3FFF_FFFF);
    c = a + (b >> 30);
    r = (c + (64'd1 << 29)) >> 30;
    return r[QW_W-1:0];
  endfunction

  // entry r of the cosine quarter wave, 0 <= r <= 2^(tb-2)
  function automatic logic [QW_W-1:0] qwave_entry(input int tb, input int r);
    logic [63:0] q, v;
    q = 64'd1 << (tb - 2);
    if (64'(r) <= (q >> 1)) begin
      v = trig_q60(angle_q60(tb, 64'(r)), 1'b0);
    end else begin
      v = trig_q60(angle_q60(tb, q - 64'(r)), 1'b1);
    end
    if (v > Q60_ONE) begin
      v = Q60_ONE;
    end
    return scale_round(v);
  endfunction

endpackage

`default_nettype wire

@@ src/hw3v_if.sv @@
// valid/ready channel interfaces for voxel transactions and windowed results
// depends on hw3v_pkg
`default_nettype none

interface hw3v_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hw3v_pkg::SAMPLE_W-1:0] sample;
  logic        [hw3v_pkg::COORD_W-1:0]  row_index;
  logic        [hw3v_pkg::COORD_W-1:0]  col_index;
  logic        [hw3v_pkg::COORD_W-1:0]  layer_index;

  modport source (output valid, sample, row_index, col_index, layer_index, input ready);
  modport sink   (input valid, sample, row_index, col_index, layer_index, output ready);
endinterface

interface hw3v_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hw3v_pkg::SAMPLE_W-1:0] windowed;

  modport source (output valid, windowed, input ready);
  modport sink   (input valid, windowed, output ready);
endinterface

`default_nettype wire

@@ src/hann_window_3d_voxel_unit.sv @@
// Separable 3d hann window: one voxel sample and its row, column and layer coordinates
// go in, the sample scaled by three axis weights taken from a cosine quarter-wave rom
// comes out. Throughput is one voxel per cycle unless the output stalls; there are six
// register stages (phase multiply, rom read, first weight multiply, second weight
// multiply, split sample multiply, output register). Each stage holds its contents
// only while the stage behind it is full and stalled, so bubbles collapse and the
// input keeps flowing while a result waits. The rom is constant and needs no clearing
// pass after reset. Registers: 0 step_row, 1 step_col, 2 step_layer, 3 window_on;
// write them only while no transaction is in flight.
// depends on hw3v_pkg and hw3v_if
`default_nettype none

module hann_window_3d_voxel_unit #(
  parameter int TABLE_BITS = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [hw3v_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [hw3v_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  hw3v_in_if.sink                                 samples_i,
  hw3v_out_if.source                              result_o
);

  localparam int QLEN = 2 ** (TABLE_BITS - 2);
  localparam int AW   = TABLE_BITS - 1;
  localparam int SW   = hw3v_pkg::SAMPLE_W;
  localparam int CW   = hw3v_pkg::COORD_W;
  localparam int TW   = hw3v_pkg::STEP_W;
  localparam int QW   = hw3v_pkg::QW_W;
  localparam int WW   = hw3v_pkg::WEIGHT_W;
  localparam int PW   = 3 * WW;
  localparam int HW   = PW / 2;
  localparam int MW   = SW + HW + 1;

  typedef logic [QW-1:0] qwave_t [QLEN+1];

  function automatic qwave_t build_qwave();
    qwave_t t;
    for (int r = 0; r <= QLEN; r++) begin
      t[r] = hw3v_pkg::qwave_entry(TABLE_BITS, r);
    end
    return t;
  endfunction

  localparam qwave_t QWAVE = build_qwave();

  // configuration
  logic [TW-1:0] step_q [3];
  logic          win_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q[0] <= '0;
      step_q[1] <= '0;
      step_q[2] <= '0;
      win_on_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hw3v_pkg::CFG_STEP_ROW:   step_q[0] <= cfg_data_i[TW-1:0];
        hw3v_pkg::CFG_STEP_COL:   step_q[1] <= cfg_data_i[TW-1:0];
        hw3v_pkg::CFG_STEP_LAYER: step_q[2] <= cfg_data_i[TW-1:0];
        hw3v_pkg::CFG_WINDOW_ON:  win_on_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  always_comb begin
    en6 = !v6_q || result_o.ready;
    en5 = !v5_q || en6;
    en4 = !v4_q || en5;
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
  end

  assign samples_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= samples_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // sample and mode travel alongside
  logic signed [SW-1:0] smp1_q, smp2_q, smp3_q, smp4_q, smp5_q;
  logic                 won1_q, won2_q, won3_q, won4_q, won5_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      smp1_q <= samples_i.sample;
      won1_q <= win_on_q;
    end
    if (en2) begin
      smp2_q <= smp1_q;
      won2_q <= won1_q;
    end
    if (en3) begin
      smp3_q <= smp2_q;
      won3_q <= won2_q;
    end
    if (en4) begin
      smp4_q <= smp3_q;
      won4_q <= won3_q;
    end
    if (en5) begin
      smp5_q <= smp4_q;
      won5_q <= won4_q;
    end
  end

  // per axis: phase index, rom read, weight
  logic [CW-1:0]         coord [3];
  logic [TABLE_BITS-1:0] idx1_q [3];
  logic [QW-1:0]         cos2_q [3];
  logic                  neg2_q [3];
  logic [WW-1:0]         weight [3];

  assign coord[0] = samples_i.row_index;
  assign coord[1] = samples_i.col_index;
  assign coord[2] = samples_i.layer_index;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [CW+TW-1:0]      phase_prod;
    logic [TABLE_BITS:0]   m;
    logic [TABLE_BITS:0]   raddr_full;
    logic [AW-1:0]         raddr;
    logic                  neg;

    assign phase_prod = (CW+TW)'(coord[a]) * (CW+TW)'(step_q[a]);

    always_ff @(posedge clk_i) begin
      if (en1) begin
        idx1_q[a] <= phase_prod[TW-1 -: TABLE_BITS];
      end
    end

    always_comb begin
      m = (TABLE_BITS+1)'(idx1_q[a]);
      if (m <= (TABLE_BITS+1)'(QLEN)) begin
        raddr_full = m;
        neg        = 1'b0;
      end else if (m <= (TABLE_BITS+1)'(2 * QLEN)) begin
        raddr_full = (TABLE_BITS+1)'(2 * QLEN) - m;
        neg        = 1'b1;
      end else if (m <= (TABLE_BITS+1)'(3 * QLEN)) begin
        raddr_full = m - (TABLE_BITS+1)'(2 * QLEN);
        neg        = 1'b1;
      end else begin
        raddr_full = (TABLE_BITS+1)'(4 * QLEN) - m;
        neg        = 1'b0;
      end
      raddr = raddr_full[AW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en2) begin
        cos2_q[a] <= QWAVE[raddr];
        neg2_q[a] <= neg;
      end
    end

    assign weight[a] = neg2_q[a] ? WW'(hw3v_pkg::AMP) + WW'(cos2_q[a])
                                 : WW'(hw3v_pkg::AMP) - WW'(cos2_q[a]);
  end

  // weight product
  logic [2*WW-1:0] wrc3_q;
  logic [WW-1:0]   wl3_q;
  logic [PW-1:0]   p4_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      wrc3_q <= (2*WW)'(weight[0]) * (2*WW)'(weight[1]);
      wl3_q  <= weight[2];
    end
    if (en4) begin
      p4_q <= PW'(wrc3_q) * PW'(wl3_q);
    end
  end

  // sample times product, split in two halves
  logic signed [MW-1:0] hi5_q, lo5_q;
  logic signed [HW:0]   ph_s, pl_s;

  assign ph_s = $signed({1'b0, p4_q[PW-1:HW]});
  assign pl_s = $signed({1'b0, p4_q[HW-1:0]});

  always_ff @(posedge clk_i) begin
    if (en5) begin
      hi5_q <= MW'(smp4_q) * MW'(ph_s);
      lo5_q <= MW'(smp4_q) * MW'(pl_s);
    end
  end

  // floor shifts and output register
  logic signed [MW-1:0] sum6;
  logic signed [MW-1:0] res6;
  logic signed [SW-1:0] win6_q;

  assign sum6 = hi5_q + (lo5_q >>> HW);
  assign res6 = sum6 >>> HW;

  always_ff @(posedge clk_i) begin
    if (en6) begin
      win6_q <= won5_q ? res6[SW-1:0] : smp5_q;
    end
  end

  assign result_o.valid    = v6_q;
  assign result_o.windowed = win6_q;

endmodule

`default_nettype wire

@@ src/hw3v_checker.sv @@
// port-level checker for the hann window voxel unit, bound into hann_window_3d_voxel_unit
// depends on hw3v_pkg and hann_window_3d_voxel_unit
`default_nettype none

module hw3v_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_i,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic [hw3v_pkg::SAMPLE_W-1:0]      windowed_i
);

  logic [3:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 4'd1;
    end else if (!in_acc && out_acc) begin
      cnt_q <= cnt_q - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(windowed_i))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 4'd0)
    else $error("result without a pending transaction");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(hw3v_pkg::PIPE_DEPTH))
    else $error("more transactions in flight than pipeline stages");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while output is free");

endmodule

bind hann_window_3d_voxel_unit hw3v_checker u_hw3v_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (samples_i.valid),
  .in_ready_i  (samples_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .windowed_i  (result_o.windowed)
);

`default_nettype wire

@@ verif/tb.sv @@
// self-checking testbench for hann_window_3d_voxel_unit: voxel transactions in, windowed
// samples out, each result checked against an in-bench fixed-point hann window predictor
// depends on hw3v_pkg, hw3v_if and the unit itself
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] QTR_PI_Q60  = 64'h0C90_FDAA_2216_8C23;
  localparam int          QTR_LEN     = 1024;
  localparam int          WD_LIMIT    = 2000;
  localparam int          DRAIN_WAIT  = 8;
  localparam int          RAND_PHASES = 10;
  localparam int          PHASE_ITEMS = 140;

  typedef struct packed {
    logic signed [hw3v_pkg::SAMPLE_W-1:0] sample;
    logic        [hw3v_pkg::COORD_W-1:0]  row;
    logic        [hw3v_pkg::COORD_W-1:0]  col;
    logic        [hw3v_pkg::COORD_W-1:0]  layer;
  } voxel_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [hw3v_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [hw3v_pkg::CFG_DATA_W-1:0] cfg_data;

  hw3v_in_if  vox_ch ();
  hw3v_out_if res_ch ();

  hann_window_3d_voxel_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .samples_i  (vox_ch),
    .result_o   (res_ch)
  );

  // predictor copy of the registers
  logic [hw3v_pkg::STEP_W-1:0] step_row_q;
  logic [hw3v_pkg::STEP_W-1:0] step_col_q;
  logic [hw3v_pkg::STEP_W-1:0] step_layer_q;
  logic                        window_on_q;

  int cos_quarter [0:QTR_LEN];
  logic signed [hw3v_pkg::SAMPLE_W-1:0] windowed_q [$];

  bit src_idle_en;
  bit sink_idle_en;
  int hold_len;
  int voxels_sent;
  int results_checked;
  int errors;
  int reg_loads;
  int quiet_cycles;
  logic signed [hw3v_pkg::SAMPLE_W-1:0] want;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [63:0] q60_mult(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, ll, mid, hi;
    ah  = a >> 32;
    al  = a & 64'hFFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFF_FFFF;
    ll  = al * bl;
    mid = ah * bl + al * bh + (ll >> 32);
    hi  = ah * bh + (mid >> 32);
    return (hi << 4) + ((mid & 64'hFFFF_FFFF) >> 28);
  endfunction

  function automatic logic [63:0] sweep_angle(input logic [63:0] t);
    return (QTR_PI_Q60 >> 9) * t + (((QTR_PI_Q60 & 64'h1FF) * t) >> 9);
  endfunction

  function automatic logic [63:0] taylor_eval(input logic [63:0] x, input bit odd);
    logic [63:0] x2, term, acc, div;
    int          n;
    x2   = q60_mult(x, x);
    term = odd ? x : ONE_Q60;
    acc  = term;
    for (n = 1; n <= 24; n++) begin
      div  = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = q60_mult(term, x2) / div;
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  function automatic int to_amp(input logic [63:0] v);
    logic [63:0] a, b, c;
    a = 64'd32767 * (v >> 30);
    b = 64'd32767 * (v & 64'h3FFF_FFFF);
    c = a + (b >> 30);
    c = (c + (64'd1 << 29)) >> 30;
    return int'(c);
  endfunction

  function automatic void build_cos_quarter();
    logic [63:0] v;
    int          r;
    for (r = 0; r <= QTR_LEN; r++) begin
      if (r <= QTR_LEN / 2) begin
        v = taylor_eval(sweep_angle(64'(r)), 1'b0);
      end else begin
        v = taylor_eval(sweep_angle(64'(QTR_LEN - r)), 1'b1);
      end
      if (v > ONE_Q60) begin
        v = ONE_Q60;
      end
      cos_quarter[r] = to_amp(v);
    end
  endfunction

  function automatic int cos_lookup(input logic [11:0] m);
    int k;
    k = int'(m);
    if (k <= QTR_LEN) begin
      return cos_quarter[k];
    end else if (k <= 2 * QTR_LEN) begin
      return -cos_quarter[2 * QTR_LEN - k];
    end else if (k <= 3 * QTR_LEN) begin
      return -cos_quarter[k - 2 * QTR_LEN];
    end else begin
      return cos_quarter[4 * QTR_LEN - k];
    end
  endfunction

  function automatic logic [47:0] axis_gain(input logic [hw3v_pkg::COORD_W-1:0] coord,
                                            input logic [hw3v_pkg::STEP_W-1:0] step);
    logic [31:0] phase;
    int          g;
    phase = step * {19'd0, coord};
    g     = 32767 - cos_lookup(phase[31:20]);
    return 48'(g);
  endfunction

  function automatic logic signed [hw3v_pkg::SAMPLE_W-1:0] predict_windowed(input voxel_t v);
    logic        [47:0] gains;
    logic signed [79:0] full;
    logic signed [79:0] shifted;
    if (!window_on_q) begin
      return v.sample;
    end
    gains   = axis_gain(v.row, step_row_q) * axis_gain(v.col, step_col_q)
            * axis_gain(v.layer, step_layer_q);
    full    = $signed(v.sample) * $signed({32'd0, gains});
    shifted = full >>> 48;
    return shifted[hw3v_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic logic [hw3v_pkg::STEP_W-1:0] step_for(input int n);
    logic [63:0] t;
    t = (((64'd1 << 33) / 64'(n)) + 64'd1) >> 1;
    return t[hw3v_pkg::STEP_W-1:0];
  endfunction

  function automatic voxel_t vox(input int s, input int r, input int c, input int l);
    voxel_t v;
    v.sample = hw3v_pkg::SAMPLE_W'(s);
    v.row    = hw3v_pkg::COORD_W'(r);
    v.col    = hw3v_pkg::COORD_W'(c);
    v.layer  = hw3v_pkg::COORD_W'(l);
    return v;
  endfunction

  function automatic logic [hw3v_pkg::COORD_W-1:0] pick_coord(input int n);
    if ($urandom_range(0, 99) < 85) begin
      return hw3v_pkg::COORD_W'($urandom_range(1, n));
    end
    return hw3v_pkg::COORD_W'($urandom);
  endfunction

  function automatic voxel_t random_voxel(input int nr, input int nc, input int nl);
    voxel_t v;
    case ($urandom_range(0, 19))
      0:       v.sample = {1'b0, {(hw3v_pkg::SAMPLE_W-1){1'b1}}};
      1:       v.sample = {1'b1, {(hw3v_pkg::SAMPLE_W-1){1'b0}}};
      default: v.sample = hw3v_pkg::SAMPLE_W'($urandom);
    endcase
    v.row   = pick_coord(nr);
    v.col   = pick_coord(nc);
    v.layer = pick_coord(nl);
    return v;
  endfunction

  // called at a rising edge, returns at the edge that accepts the transaction
  task automatic send_voxel(input voxel_t v);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      vox_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vox_ch.valid       <= 1'b1;
    vox_ch.sample      <= v.sample;
    vox_ch.row_index   <= v.row;
    vox_ch.col_index   <= v.col;
    vox_ch.layer_index <= v.layer;
    do @(posedge clk); while (vox_ch.ready !== 1'b1);
    windowed_q.push_back(predict_windowed(v));
    voxels_sent++;
  endtask

  task automatic drain_pipe();
    vox_ch.valid <= 1'b0;
    while (windowed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic load_regs(input logic [hw3v_pkg::STEP_W-1:0] sr,
                           input logic [hw3v_pkg::STEP_W-1:0] sc,
                           input logic [hw3v_pkg::STEP_W-1:0] sl, input logic win);
    cfg_we   <= 1'b1;
    cfg_idx  <= hw3v_pkg::CFG_STEP_ROW;
    cfg_data <= sr;
    @(posedge clk);
    cfg_idx  <= hw3v_pkg::CFG_STEP_COL;
    cfg_data <= sc;
    @(posedge clk);
    cfg_idx  <= hw3v_pkg::CFG_STEP_LAYER;
    cfg_data <= sl;
    @(posedge clk);
    cfg_idx  <= hw3v_pkg::CFG_WINDOW_ON;
    cfg_data <= {31'($urandom_range(0, 32'h7FFF_FFFF)), win};
    @(posedge clk);
    cfg_we       <= 1'b0;
    step_row_q   = sr;
    step_col_q   = sc;
    step_layer_q = sl;
    window_on_q  = win;
    reg_loads++;
  endtask

  // steps are zero after reset, so every weight is zero
  task automatic test_reset_state();
    send_voxel(vox(131071, 1, 1, 1));
    send_voxel(vox(-131072, 4096, 4096, 4096));
    send_voxel(vox(-1, 8191, 0, 2048));
    drain_pipe();
  endtask

  task automatic test_bypass();
    load_regs(32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_voxel(vox(131071, 1, 2, 3));
    send_voxel(vox(-131072, 4096, 8191, 0));
    send_voxel(vox(0, 17, 33, 65));
    send_voxel(vox(-1, 5461, 2730, 1365));
    drain_pipe();
  endtask

  task automatic test_peak_weights();
    load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_voxel(vox(131071, 1, 1, 1));
    send_voxel(vox(-131072, 1, 1, 1));
    send_voxel(vox(-131072, 2, 2, 2));
    send_voxel(vox(131071, 8191, 8191, 8191));
    send_voxel(vox(-77777, 0, 1, 3));
    drain_pipe();
  endtask

  task automatic test_extreme_steps();
    load_regs(32'hFFFF_FFFF, step_for(4096), step_for(3), 1'b1);
    send_voxel(vox(131071, 1, 1, 1));
    send_voxel(vox(-131072, 4096, 4096, 4096));
    send_voxel(vox(1, 2048, 1024, 2));
    send_voxel(vox(-1, 3072, 3071, 1));
    send_voxel(vox(99999, 8191, 1025, 4095));
    send_voxel(vox(-54321, 1500, 2049, 3));
    drain_pipe();
  endtask

  // receiver stalls long while the sender keeps offering back to back
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_len    = 80;
    repeat (40) send_voxel(random_voxel(4096, 4096, 4096));
    drain_pipe();
    src_idle_en = 1'b1;
  endtask

  task automatic test_random_sweeps();
    logic [hw3v_pkg::STEP_W-1:0] steps [3];
    int                          sizes [3];
    int                          p, a;
    for (p = 0; p < RAND_PHASES; p++) begin
      for (a = 0; a < 3; a++) begin
        sizes[a] = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 4096)
                                               : $urandom_range(2, 64);
        case ($urandom_range(0, 9))
          0:       steps[a] = '0;
          1:       steps[a] = '1;
          2:       steps[a] = $urandom;
          default: steps[a] = step_for(sizes[a]);
        endcase
      end
      load_regs(steps[0], steps[1], steps[2], (p % 4 != 3));
      src_idle_en  = (p % 4 == 0) || (p % 4 == 2);
      sink_idle_en = (p % 4 == 0) || (p % 4 == 3);
      repeat (PHASE_ITEMS) send_voxel(random_voxel(sizes[0], sizes[1], sizes[2]));
      drain_pipe();
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // result receiver
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
      end else begin
        stall = sink_idle_en ? $urandom_range(0, 5) : 0;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (windowed_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %0d",
                 $time, res_ch.windowed);
        errors++;
      end else begin
        want = windowed_q.pop_front();
        results_checked++;
        if (res_ch.windowed !== want) begin
          $display("%0t: windowed mismatch, expected %0d, actual %0d",
                   $time, want, res_ch.windowed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((vox_ch.valid === 1'b1 && vox_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WD_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, WD_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= hw3v_pkg::CFG_STEP_ROW;
    cfg_data           <= '0;
    vox_ch.valid       <= 1'b0;
    vox_ch.sample      <= '0;
    vox_ch.row_index   <= '0;
    vox_ch.col_index   <= '0;
    vox_ch.layer_index <= '0;
    quiet_cycles       <= 0;
    step_row_q   = '0;
    step_col_q   = '0;
    step_layer_q = '0;
    window_on_q  = 1'b1;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    hold_len     = 0;
    voxels_sent  = 0;
    results_checked = 0;
    errors       = 0;
    reg_loads    = 0;
    build_cos_quarter();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_bypass();
    test_peak_weights();
    test_extreme_steps();
    test_backpressure();
    test_random_sweeps();

    drain_pipe();
    repeat (20) @(posedge clk);
    $display("run: %0d voxels sent over %0d register loads, %0d results checked",
             voxels_sent, reg_loads, results_checked);
    $display("run: bypass, zero and extreme steps, wrapped coordinates, long receiver stall");
    if (errors == 0 && windowed_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
src/hw3v_pkg.sv
src/hw3v_if.sv
src/hann_window_3d_voxel_unit.sv
src/hw3v_checker.sv
verif/tb.sv
